// ===== hdl/rsf_pkg.sv =====
// Shared types, codes and helpers for the RGB555 screen fade block.
`timescale 1ns / 1ps

package rsf_pkg;

  localparam logic [5:0] FULL_LEVEL = 6'd32;
  localparam int unsigned CHAN_W = 5;
  localparam int unsigned PIX_W = 15;
  localparam int unsigned CHANNELS = 3;
  localparam logic [1:0] CFG_FADE_COLOR = 2'd0;
  localparam logic [1:0] CFG_FADE_SPEED = 2'd1;
  // floor(32*d/100) = floor(d*1311 / 4096) for d below 128
  localparam logic [18:0] DEPTH_RECIP = 19'd1311;

  typedef enum logic [2:0] {
    REQ_PIXEL   = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_FADE_IN = 3'd2,
    REQ_FADE_OUT = 3'd3,
    REQ_FILTER  = 3'd4,
    REQ_CANCEL  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_IN     = 2'd1,
    MODE_OUT    = 2'd2,
    MODE_FILTER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_PASS  = 2'd1,
    SEL_COLOR = 2'd2,
    SEL_BLEND = 2'd3
  } pix_sel_t;

  typedef struct packed {
    logic [5:0] level;
    logic       in_done;
    logic       out_done;
  } status_t;

  function automatic logic [5:0] depth_to_level(input logic [6:0] depth);
    logic [18:0] prod;
    logic [6:0]  lvl;
    prod = {12'd0, depth} * DEPTH_RECIP;
    lvl = prod[18:12];
    if (lvl > {1'b0, FULL_LEVEL}) begin
      lvl = {1'b0, FULL_LEVEL};
    end
    return lvl[5:0];
  endfunction

endpackage

// ===== hdl/rsf_lane.sv =====
// One blend lane: mixes a single RGB555 pixel toward the fade color.
`timescale 1ns / 1ps

module rsf_lane (
  input  logic [14:0] pixel,
  input  logic [14:0] color,
  input  logic [5:0]  level,
  output logic [14:0] mixed
);
  import rsf_pkg::*;

  logic [5:0] inv_level;

  assign inv_level = FULL_LEVEL - level;

  always_comb begin
    logic [10:0] prod_c;
    logic [10:0] prod_d;
    logic [5:0]  sum;
    mixed = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod_c = {6'd0, pixel[ch*CHAN_W +: CHAN_W]} * {5'd0, level};
      prod_d = {6'd0, color[ch*CHAN_W +: CHAN_W]} * {5'd0, inv_level};
      sum = prod_c[10:5] + prod_d[10:5];
      mixed[ch*CHAN_W +: CHAN_W] = sum[4:0];
    end
  end

endmodule

// ===== hdl/rsf_out.sv =====
// Merge stage: picks pair, color, blended lanes or zero and holds the output.
`timescale 1ns / 1ps

module rsf_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [14:0]       lane_hi,
  input  logic [14:0]       lane_lo,
  input  logic [31:0]       pair,
  input  logic [14:0]       color,
  input  rsf_pkg::pix_sel_t sel,
  input  rsf_pkg::status_t  stat,
  output logic              take_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata   // blended_pair[31:0], fade_level[37:32],
                                      // fade_in_done[38], fade_out_done[39]
);
  import rsf_pkg::*;

  logic [31:0] word;

  always_comb begin
    case (sel)
      SEL_PASS:  word = pair;
      SEL_COLOR: word = {1'b0, color, 1'b0, color};
      SEL_BLEND: word = {1'b0, lane_hi, 1'b0, lane_lo};
      default:   word = '0;
    endcase
  end

  assign take_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {stat.out_done, stat.in_done, stat.level, word};
    end
  end

endmodule

// ===== hdl/rgb555_screen_fade_top.sv =====
// An accepted item's result is registered, valid on the master side next cycle.
// Throughput: one item per clock; a result not yet taken holds off the next item.
// Both pixel lanes and the level/mode update finish in the accepting cycle.
// Reset: level 32, mode none, done flags clear, fade color 0, fade speed 1,
// output empty.
`timescale 1ns / 1ps

module rgb555_screen_fade_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_pair[31:0], depth_percent[38:32], zero[39]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // blended_pair[31:0], fade_level[37:32],
                                 // fade_in_done[38], fade_out_done[39]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import rsf_pkg::*;

  logic [14:0] fade_color;
  logic [5:0]  fade_speed;
  logic [5:0]  level;
  logic [5:0]  level_next;
  mode_t       mode;
  mode_t       mode_next;
  logic        in_done;
  logic        in_done_next;
  logic        out_done;
  logic        out_done_next;

  logic        s_fire;
  req_t        req;
  logic [31:0] pair;
  logic [6:0]  depth;
  logic [14:0] lane_hi;
  logic [14:0] lane_lo;
  pix_sel_t    sel;
  status_t     stat;
  logic [6:0]  up_sum;

  assign req    = req_t'(s_tuser);
  assign pair   = s_tdata[31:0];
  assign depth  = s_tdata[38:32];
  assign s_fire = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign up_sum = {1'b0, level} + {1'b0, fade_speed};

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_color <= '0;
      fade_speed <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FADE_COLOR: fade_color <= cfg_data;
        CFG_FADE_SPEED: fade_speed <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level_next    = level;
    mode_next     = mode;
    in_done_next  = in_done;
    out_done_next = out_done;
    sel           = SEL_ZERO;
    stat.in_done  = 1'b0;
    stat.out_done = 1'b0;
    case (req)
      REQ_PIXEL: begin
        if (mode == MODE_NONE) begin
          sel = SEL_PASS;
        end else if (level[5]) begin
          sel = SEL_PASS;
          if (mode == MODE_IN) begin
            in_done_next = 1'b1;
          end
        end else if (level == 6'd0) begin
          sel = SEL_COLOR;
          if (mode == MODE_OUT) begin
            out_done_next = 1'b1;
          end
        end else begin
          sel = SEL_BLEND;
        end
      end
      REQ_TICK: begin
        stat.in_done  = in_done || (mode == MODE_IN && level[5]);
        stat.out_done = out_done || (mode == MODE_OUT && level == 6'd0);
        if (mode == MODE_IN) begin
          level_next = (up_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : up_sum[5:0];
        end else if (mode == MODE_OUT) begin
          level_next = (level > fade_speed) ? level - fade_speed : 6'd0;
        end
        in_done_next  = 1'b0;
        out_done_next = 1'b0;
      end
      REQ_FADE_IN: begin
        level_next    = 6'd0;
        mode_next     = MODE_IN;
        out_done_next = 1'b0;
      end
      REQ_FADE_OUT: begin
        level_next   = FULL_LEVEL;
        mode_next    = MODE_OUT;
        in_done_next = 1'b0;
      end
      REQ_FILTER: begin
        level_next   = depth_to_level(depth);
        mode_next    = MODE_FILTER;
        in_done_next = 1'b0;
      end
      REQ_CANCEL: begin
        mode_next    = MODE_NONE;
        in_done_next = 1'b0;
      end
      default: ;
    endcase
    stat.level = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= FULL_LEVEL;
      mode     <= MODE_NONE;
      in_done  <= 1'b0;
      out_done <= 1'b0;
    end else if (s_fire) begin
      level    <= level_next;
      mode     <= mode_next;
      in_done  <= in_done_next;
      out_done <= out_done_next;
    end
  end

  rsf_lane u_lane_hi (
    .pixel (pair[30:16]),
    .color (fade_color),
    .level (level),
    .mixed (lane_hi)
  );

  rsf_lane u_lane_lo (
    .pixel (pair[14:0]),
    .color (fade_color),
    .level (level),
    .mixed (lane_lo)
  );

  rsf_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s_fire),
    .lane_hi    (lane_hi),
    .lane_lo    (lane_lo),
    .pair       (pair),
    .color      (fade_color),
    .sel        (sel),
    .stat       (stat),
    .take_ready (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= FULL_LEVEL)
    else $error("fade level above full scale");

  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    s_fire && req == REQ_TICK |=> !in_done && !out_done)
    else $error("done flags not cleared after tick");

  a_fade_in_start: assert property (@(posedge clk) disable iff (rst)
    s_fire && req == REQ_FADE_IN |=> level == 6'd0 && mode == MODE_IN)
    else $error("fade in did not start at level zero");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_tvalid && m_tdata[37:32] == $past(level_next))
    else $error("result item missing or wrong level");

endmodule

// ===== bench/tb_rgb555_screen_fade_top.sv =====
// Self-checking bench for the RGB555 screen fade block: stream stimulus and result scoreboard.
`timescale 1ns / 1ps

module tb_rgb555_screen_fade_top;
  import rsf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int unsigned LEVEL_TOP = 32;
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic        out_done;
    logic        in_done;
    logic [5:0]  level;
    logic [31:0] pair;
  } fade_result_t;

  class fade_scoreboard;
    logic [14:0]    color;
    logic [5:0]     speed;
    int unsigned    level;
    mode_t          mode;
    bit             in_flag;
    bit             out_flag;
    fade_result_t   pending_results[$];
    int unsigned    errors;

    function new();
      color = '0;
      speed = 6'd1;
      level = LEVEL_TOP;
      mode = MODE_NONE;
      in_flag = 1'b0;
      out_flag = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [14:0] value);
      if (index == CFG_FADE_COLOR) begin
        color = value;
      end else if (index == CFG_FADE_SPEED) begin
        speed = value[5:0];
      end
    endfunction

    function logic [4:0] blend_channel(logic [4:0] c, logic [4:0] d);
      int unsigned sum;
      sum = ((int'(c) * level) >> 5) + ((int'(d) * (LEVEL_TOP - level)) >> 5);
      return sum[4:0];
    endfunction

    function logic [14:0] blend_pixel(logic [14:0] p);
      return {blend_channel(p[14:10], color[14:10]),
              blend_channel(p[9:5], color[9:5]),
              blend_channel(p[4:0], color[4:0])};
    endfunction

    function logic [31:0] fade_pair(logic [31:0] pair);
      if (mode == MODE_NONE) begin
        return pair;
      end
      if (level >= LEVEL_TOP) begin
        if (mode == MODE_IN) begin
          in_flag = 1'b1;
        end
        return pair;
      end
      if (level == 0) begin
        if (mode == MODE_OUT) begin
          out_flag = 1'b1;
        end
        return {1'b0, color, 1'b0, color};
      end
      return {1'b0, blend_pixel(pair[30:16]), 1'b0, blend_pixel(pair[14:0])};
    endfunction

    function void note_input(logic [2:0] req, logic [31:0] pair, logic [6:0] depth);
      fade_result_t r;
      r = '0;
      case (req)
        REQ_PIXEL: r.pair = fade_pair(pair);
        REQ_TICK: begin
          if (mode == MODE_IN && level >= LEVEL_TOP) begin
            in_flag = 1'b1;
          end
          if (mode == MODE_OUT && level == 0) begin
            out_flag = 1'b1;
          end
          if (mode == MODE_IN) begin
            level = (level + speed > LEVEL_TOP) ? LEVEL_TOP : level + speed;
          end else if (mode == MODE_OUT) begin
            level = (level > speed) ? level - speed : 0;
          end
          r.in_done = in_flag;
          r.out_done = out_flag;
          in_flag = 1'b0;
          out_flag = 1'b0;
        end
        REQ_FADE_IN: begin
          level = 0;
          mode = MODE_IN;
          out_flag = 1'b0;
        end
        REQ_FADE_OUT: begin
          level = LEVEL_TOP;
          mode = MODE_OUT;
          in_flag = 1'b0;
        end
        REQ_FILTER: begin
          in_flag = 1'b0;
          level = (LEVEL_TOP * depth) / 100;
          if (level > LEVEL_TOP) begin
            level = LEVEL_TOP;
          end
          mode = MODE_FILTER;
        end
        REQ_CANCEL: begin
          mode = MODE_NONE;
          in_flag = 1'b0;
        end
        default: ;
      endcase
      r.level = level[5:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(fade_result_t got);
      fade_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected: expected nothing, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.pair !== want.pair) begin
        $display("%0t: blended_pair expected %h, got %h", $time, want.pair, got.pair);
        errors++;
      end
      if (got.level !== want.level) begin
        $display("%0t: fade_level expected %0d, got %0d", $time, want.level, got.level);
        errors++;
      end
      if (got.in_done !== want.in_done) begin
        $display("%0t: fade_in_done expected %b, got %b", $time, want.in_done, got.in_done);
        errors++;
      end
      if (got.out_done !== want.out_done) begin
        $display("%0t: fade_out_done expected %b, got %b", $time, want.out_done, got.out_done);
        errors++;
      end
    endfunction

    function int unsigned waiting();
      return pending_results.size();
    endfunction
  endclass

  bit          clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;
  bit          quiet;
  fade_scoreboard sb;

  rgb555_screen_fade_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send(logic [2:0] req, logic [31:0] pair, logic [6:0] depth);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {1'b0, depth, pair};
    do @(posedge clk); while (!s_tready);
    sb.note_input(req, pair, depth);
  endtask

  task automatic send_random();
    logic [2:0]  req;
    logic [31:0] pair;
    logic [6:0]  depth;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 53) begin
      req = REQ_PIXEL;
    end else if (r < 83) begin
      req = REQ_TICK;
    end else if (r < 87) begin
      req = REQ_FADE_IN;
    end else if (r < 91) begin
      req = REQ_FADE_OUT;
    end else if (r < 95) begin
      req = REQ_FILTER;
    end else if (r < 97) begin
      req = REQ_CANCEL;
    end else begin
      req = ($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    r = $urandom_range(0, 19);
    pair = (r == 0) ? '1 : (r == 1) ? '0 : $urandom();
    if ($urandom_range(0, 9) == 0) begin
      depth = 7'($urandom_range(101, 127));
    end else begin
      depth = 7'($urandom_range(0, 100));
    end
    send(req, pair, depth);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] index, logic [14:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    fade_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          stall--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("rgb555_screen_fade_top test failed");
    $finish;
  end

  initial begin
    logic [5:0]  speed;
    logic [14:0] color;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_PIXEL;
    cfg_valid = 1'b0;
    cfg_index = CFG_FADE_COLOR;
    cfg_data = '0;
    quiet = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: black target, unit step
    send(REQ_PIXEL, 32'hFFFF_FFFF, 7'd0);
    send(REQ_PIXEL, 32'h0000_0000, 7'h7F);
    send(REQ_TICK, $urandom(), 7'($urandom()));
    send(REQ_SPARE_A, $urandom(), 7'($urandom()));
    send(REQ_SPARE_B, $urandom(), 7'($urandom()));
    send(REQ_FADE_IN, $urandom(), 7'($urandom()));
    send(REQ_PIXEL, 32'hFFFF_FFFF, 7'd0);
    send(REQ_TICK, $urandom(), 7'($urandom()));
    send(REQ_PIXEL, 32'h7FFF_7FFF, 7'd0);
    send(REQ_FILTER, $urandom(), 7'd0);
    send(REQ_PIXEL, $urandom(), 7'd0);
    send(REQ_FILTER, $urandom(), 7'd100);
    send(REQ_PIXEL, 32'hFFFF_FFFF, 7'd0);
    send(REQ_FILTER, $urandom(), 7'd127);
    send(REQ_FILTER, $urandom(), 7'd50);
    send(REQ_PIXEL, $urandom(), 7'd0);
    send(REQ_CANCEL, $urandom(), 7'd0);
    send(REQ_PIXEL, $urandom(), 7'd0);
    drain();

    // white target, oversize step: fade-out completion flag; a cancel clears the fade-in flag before a tick reports it
    write_cfg(CFG_FADE_COLOR, 15'h7FFF);
    write_cfg(CFG_FADE_SPEED, 15'h7FFF);
    send(REQ_FADE_OUT, $urandom(), 7'd0);
    send(REQ_PIXEL, 32'hFFFF_FFFF, 7'd0);
    send(REQ_TICK, $urandom(), 7'd0);
    send(REQ_PIXEL, $urandom(), 7'd0);
    send(REQ_TICK, $urandom(), 7'd0);
    send(REQ_TICK, $urandom(), 7'd0);
    send(REQ_FADE_IN, $urandom(), 7'd0);
    send(REQ_PIXEL, $urandom(), 7'd0);
    send(REQ_TICK, $urandom(), 7'd0);
    send(REQ_PIXEL, $urandom(), 7'd0);
    send(REQ_CANCEL, $urandom(), 7'd0);
    send(REQ_TICK, $urandom(), 7'd0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p % 4 == 2);
      case (p)
        0: speed = 6'd63;
        1: speed = 6'd0;
        2: speed = 6'd32;
        3: speed = 6'd1;
        default: speed = 6'($urandom_range(2, 16));
      endcase
      case (p)
        0: color = 15'h7FFF;
        1: color = 15'h0000;
        default: color = 15'($urandom());
      endcase
      write_cfg(CFG_FADE_SPEED, {9'($urandom()), speed});
      write_cfg(CFG_FADE_COLOR, color);
      if ($urandom_range(0, 2) == 0) begin
        write_cfg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, 15'($urandom()));
      end
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("rgb555_screen_fade_top test passed");
    end else begin
      $display("rgb555_screen_fade_top test failed");
    end
    $finish;
  end

endmodule
